// ===== src/tanh_af_pkg.sv =====
// Shared types, constants and the tanh table of the tanh activation block.
package tanh_af_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int FRAC_BITS      = 12;
    localparam int TABLE_SEGMENTS = 256;
    localparam int SPAN           = 32768;
    localparam int SEG_WIDTH      = SPAN / TABLE_SEGMENTS;
    localparam int SEG_BITS       = $clog2(SEG_WIDTH);
    localparam int IDX_W          = DATA_WIDTH - SEG_BITS;
    localparam int TAB_W          = FRAC_BITS + 1;
    localparam int PROD_W         = TAB_W + SEG_BITS;
    localparam int SQ_W           = 2 * DATA_WIDTH;
    localparam int OM_W           = 2 * DATA_WIDTH - FRAC_BITS;
    localparam int GP_W           = DATA_WIDTH + OM_W;

    localparam logic REQ_FWD = 1'b0;
    localparam logic REQ_BWD = 1'b1;

    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic                         req_type;
        logic signed [DATA_WIDTH-1:0] operand_value;
        logic signed [DATA_WIDTH-1:0] saved_value;
        logic                         last_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         last_out;
    } res_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    typedef logic [TABLE_SEGMENTS:0][TAB_W-1:0] tab_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic tab_t build_tab();
        tab_t        tab;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] nn;
        logic [63:0] dd;
        logic [63:0] q;
        t    = 64'(SEG_WIDTH) << (62 - FRAC_BITS + 1);
        term = Q62_ONE;
        r    = Q62_ONE;
        e    = Q62_ONE;
        for (int i = 1; i <= 40; i++) begin
            term = udiv64(mul_q62(term, t), 64'(i));
            if (i[0]) begin
                r = r - term;
            end
            else begin
                r = r + term;
            end
        end
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            nn     = (Q62_ONE - e) >> 22;
            dd     = (Q62_ONE + e) >> 22;
            q      = udiv64((nn << (FRAC_BITS + 1)) + dd, dd << 1);
            tab[k] = q[TAB_W-1:0];
            e      = mul_q62(e, r);
        end
        return tab;
    endfunction

    localparam tab_t TANH_TAB = build_tab();

endpackage

// ===== src/tanh_activation_fwd_bwd.sv =====
// Top level of the tanh activation block with forward and backward requests.
//
// Usage:
//   req channel (req_valid/req_ready/req_data): one element per request.
//     req_type 0 gives tanh(operand_value) in Q3.12; req_type 1 gives
//     operand_value * (1 - saved_value^2), saturated to 16 bits.
//   res channel (res_valid/res_ready/res_data): one result per forward
//     request and per backward request while backward_enable is set;
//     last_out copies last_in.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes backward_enable;
//     always ready. With it clear, backward requests are taken and dropped.
// A request passes these registered stages: table lookup or y*y, the
//   interpolation or gradient multiply, then the final add or saturation.
//   Throughput is one request per cycle while res_ready is high.
// Reset clears all three pipeline valid bits and sets backward_enable.
// When res_ready is low the pipeline fills its empty stages and then holds;
//   req_ready falls only once every stage holds an element.
module tanh_activation_fwd_bwd (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tanh_af_pkg::req_t req_data,
    output logic              res_valid,
    input  logic              res_ready,
    output tanh_af_pkg::res_t res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import tanh_af_pkg::*;

    stage_en_t                    stage_en;
    logic                         res_type;
    logic                         res_last;
    logic signed [DATA_WIDTH-1:0] fwd_y;
    logic signed [DATA_WIDTH-1:0] bwd_res;

    tanh_af_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_data.req_type),
        .req_last  (req_data.last_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_type  (res_type),
        .res_last  (res_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stage_en  (stage_en)
    );

    tanh_af_fwd u_fwd (
        .clk      (clk),
        .stage_en (stage_en),
        .x        (req_data.operand_value),
        .y        (fwd_y)
    );

    tanh_af_bwd u_bwd (
        .clk      (clk),
        .stage_en (stage_en),
        .grad     (req_data.operand_value),
        .saved    (req_data.saved_value),
        .res      (bwd_res)
    );

    assign res_data.result_value = (res_type == REQ_BWD) ? bwd_res : fwd_y;
    assign res_data.last_out     = res_last;

endmodule

// ===== src/tanh_af_ctrl.sv =====
// Valid pipeline, stall chain and configuration register of the tanh block.
module tanh_af_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_type,
    input  logic                 req_last,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_type,
    output logic                 res_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output tanh_af_pkg::stage_en_t stage_en
);
    import tanh_af_pkg::*;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic l1_reg, l1_next, l2_reg, l2_next, l3_reg, l3_next;
    logic bwd_en_reg, bwd_en_next;
    logic adv1, adv2, adv3, keep;

    assign adv3      = !v3_reg || res_ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign req_ready = adv1;
    assign cfg_ready = 1'b1;
    assign keep      = (req_type == REQ_FWD) || bwd_en_reg;

    always_comb
    begin
        v1_next     = adv1 ? (req_valid && keep) : v1_reg;
        v2_next     = adv2 ? v1_reg : v2_reg;
        v3_next     = adv3 ? v2_reg : v3_reg;
        t1_next     = adv1 ? req_type : t1_reg;
        t2_next     = adv2 ? t1_reg : t2_reg;
        t3_next     = adv3 ? t2_reg : t3_reg;
        l1_next     = adv1 ? req_last : l1_reg;
        l2_next     = adv2 ? l1_reg : l2_reg;
        l3_next     = adv3 ? l2_reg : l3_reg;
        bwd_en_next = cfg_valid ? cfg_data : bwd_en_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            bwd_en_reg <= 1'b1;
        end
        else
        begin
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
            bwd_en_reg <= bwd_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t1_next;
        t2_reg <= t2_next;
        t3_reg <= t3_next;
        l1_reg <= l1_next;
        l2_reg <= l2_next;
        l3_reg <= l3_next;
    end

    assign res_valid   = v3_reg;
    assign res_type    = t3_reg;
    assign res_last    = l3_reg;
    assign stage_en.s1 = adv1;
    assign stage_en.s2 = adv2;
    assign stage_en.s3 = adv3;

endmodule

// ===== src/tanh_af_fwd.sv =====
// Forward path: table lookup, linear interpolation and sign restore.
module tanh_af_fwd (
    input  logic                                  clk,
    input  tanh_af_pkg::stage_en_t                stage_en,
    input  logic signed [tanh_af_pkg::DATA_WIDTH-1:0] x,
    output logic signed [tanh_af_pkg::DATA_WIDTH-1:0] y
);
    import tanh_af_pkg::*;

    logic [DATA_WIDTH-1:0] mag_in;
    logic [IDX_W-1:0]      idx;
    logic                  sat;
    logic [TAB_W-1:0]      lo_tab, hi_tab;

    logic                  s1_sign_reg, s1_sign_next;
    logic [TAB_W-1:0]      s1_lo_reg, s1_lo_next;
    logic [TAB_W-1:0]      s1_diff_reg, s1_diff_next;
    logic [SEG_BITS-1:0]   s1_frac_reg, s1_frac_next;
    logic                  s2_sign_reg, s2_sign_next;
    logic [TAB_W-1:0]      s2_lo_reg, s2_lo_next;
    logic [PROD_W-1:0]     s2_prod_reg, s2_prod_next;
    logic signed [DATA_WIDTH-1:0] s3_y_reg, s3_y_next;
    logic [TAB_W-1:0]      mag;

    always_comb
    begin
        mag_in = x[DATA_WIDTH-1] ? DATA_WIDTH'(-x) : DATA_WIDTH'(x);
        idx    = mag_in[DATA_WIDTH-1:SEG_BITS];
        sat    = (idx >= IDX_W'(TABLE_SEGMENTS));
        lo_tab = sat ? TANH_TAB[TABLE_SEGMENTS] : TANH_TAB[idx];
        hi_tab = sat ? TANH_TAB[TABLE_SEGMENTS] : TANH_TAB[idx + IDX_W'(1)];

        s1_sign_next = stage_en.s1 ? x[DATA_WIDTH-1] : s1_sign_reg;
        s1_lo_next   = stage_en.s1 ? lo_tab : s1_lo_reg;
        s1_diff_next = stage_en.s1 ? (hi_tab - lo_tab) : s1_diff_reg;
        s1_frac_next = stage_en.s1 ? (sat ? '0 : mag_in[SEG_BITS-1:0]) : s1_frac_reg;

        s2_sign_next = stage_en.s2 ? s1_sign_reg : s2_sign_reg;
        s2_lo_next   = stage_en.s2 ? s1_lo_reg : s2_lo_reg;
        s2_prod_next = stage_en.s2 ? (PROD_W'(s1_diff_reg) * PROD_W'(s1_frac_reg))
                                   : s2_prod_reg;

        mag       = s2_lo_reg + TAB_W'(s2_prod_reg >> SEG_BITS);
        s3_y_next = stage_en.s3 ? (s2_sign_reg ? -DATA_WIDTH'(mag) : DATA_WIDTH'(mag))
                                : s3_y_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= s1_sign_next;
        s1_lo_reg   <= s1_lo_next;
        s1_diff_reg <= s1_diff_next;
        s1_frac_reg <= s1_frac_next;
        s2_sign_reg <= s2_sign_next;
        s2_lo_reg   <= s2_lo_next;
        s2_prod_reg <= s2_prod_next;
        s3_y_reg    <= s3_y_next;
    end

    assign y = s3_y_reg;

endmodule

// ===== src/tanh_af_bwd.sv =====
// Backward path: grad * (1 - y*y) with arithmetic shifts and saturation.
module tanh_af_bwd (
    input  logic                                  clk,
    input  tanh_af_pkg::stage_en_t                stage_en,
    input  logic signed [tanh_af_pkg::DATA_WIDTH-1:0] grad,
    input  logic signed [tanh_af_pkg::DATA_WIDTH-1:0] saved,
    output logic signed [tanh_af_pkg::DATA_WIDTH-1:0] res
);
    import tanh_af_pkg::*;

    localparam logic signed [GP_W-1:0] RES_MAX = GP_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [GP_W-1:0] RES_MIN = -RES_MAX - GP_W'(1);
    localparam logic signed [OM_W-1:0] ONE_Q   = OM_W'(64'sd1 <<< FRAC_BITS);

    logic signed [DATA_WIDTH-1:0] s1_grad_reg, s1_grad_next;
    logic signed [SQ_W-1:0]       s1_sq_reg, s1_sq_next;
    logic signed [GP_W-1:0]       s2_p_reg, s2_p_next;
    logic signed [DATA_WIDTH-1:0] s3_res_reg, s3_res_next;
    logic signed [OM_W-1:0]       om;
    logic signed [GP_W-1:0]       sh;

    always_comb
    begin
        s1_grad_next = stage_en.s1 ? grad : s1_grad_reg;
        s1_sq_next   = stage_en.s1 ? (SQ_W'(saved) * SQ_W'(saved)) : s1_sq_reg;

        om        = ONE_Q - OM_W'(s1_sq_reg >>> FRAC_BITS);
        s2_p_next = stage_en.s2 ? (GP_W'(s1_grad_reg) * GP_W'(om)) : s2_p_reg;

        sh = s2_p_reg >>> FRAC_BITS;
        if (sh > RES_MAX)
        begin
            s3_res_next = DATA_WIDTH'(RES_MAX);
        end
        else if (sh < RES_MIN)
        begin
            s3_res_next = DATA_WIDTH'(RES_MIN);
        end
        else
        begin
            s3_res_next = DATA_WIDTH'(sh);
        end
        if (!stage_en.s3)
        begin
            s3_res_next = s3_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_grad_reg <= s1_grad_next;
        s1_sq_reg   <= s1_sq_next;
        s2_p_reg    <= s2_p_next;
        s3_res_reg  <= s3_res_next;
    end

    assign res = s3_res_reg;

endmodule

// ===== src/tanh_af_chk.sv =====
// Port checker for the tanh activation block and its bind statement.
module tanh_af_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              res_valid,
    input logic              res_ready,
    input tanh_af_pkg::res_t res_data
);
    logic req_acc;

    assign req_acc = req_valid && req_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid && !res_ready)
        else $error("request stalled while output can advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!req_acc && res_ready) ##1 (!req_acc && res_ready) ##1 (!req_acc && res_ready)
        |=> !res_valid)
        else $error("pipeline did not drain in three cycles");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind tanh_activation_fwd_bwd tanh_af_chk u_chk (.*);

// ===== tb/sv/tanh_activation_checker.sv =====
// Channel monitor, tanh/gradient predictor and result checker for the tanh activation block.
module tanh_activation_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  tanh_af_pkg::req_t req_data,
    input  logic              res_valid,
    input  logic              res_ready,
    input  tanh_af_pkg::res_t res_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    output int                errors,
    output int                pending
);
    import tanh_af_pkg::*;

    localparam logic [63:0] UNIT_Q62 = 64'h4000_0000_0000_0000;
    localparam int          ONE_Q12  = 1 << FRAC_BITS;

    int   tanh_lut [0:TABLE_SEGMENTS];
    res_t due_results [$];
    logic back_en    = 1'b1;
    int   fail_count = 0;
    int   due_count  = 0;

    assign errors  = fail_count;
    assign pending = due_count;

    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return 64'(wide >> 62);
    endfunction

    initial
    begin : build_lut
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] decay;
        logic [63:0] num;
        logic [63:0] den;
        // exp(-2*SEG_WIDTH/4096) by its series, then powers of it per entry
        step  = 64'(SEG_WIDTH) << 51;
        term  = UNIT_Q62;
        ratio = UNIT_Q62;
        decay = UNIT_Q62;
        for (int n = 1; n <= 40; n++)
        begin
            term = q62_product(term, step) / 64'(n);
            if (n % 2 == 1)
                ratio = ratio - term;
            else
                ratio = ratio + term;
        end
        for (int k = 0; k <= TABLE_SEGMENTS; k++)
        begin
            num         = (UNIT_Q62 - decay) >> 22;
            den         = (UNIT_Q62 + decay) >> 22;
            tanh_lut[k] = int'((64'd8192 * num + den) / (64'd2 * den));
            decay       = q62_product(decay, ratio);
        end
    end

    function automatic logic signed [DATA_WIDTH-1:0] tanh_q312(
        input logic signed [DATA_WIDTH-1:0] x);
        int xi;
        int mag_in;
        int seg;
        int frac;
        int mag;
        xi     = x;
        mag_in = (xi < 0) ? -xi : xi;
        seg    = mag_in / SEG_WIDTH;
        frac   = mag_in % SEG_WIDTH;
        if (seg >= TABLE_SEGMENTS)
            mag = tanh_lut[TABLE_SEGMENTS];
        else
            mag = tanh_lut[seg] + ((tanh_lut[seg+1] - tanh_lut[seg]) * frac) / SEG_WIDTH;
        return (xi < 0) ? DATA_WIDTH'(-mag) : DATA_WIDTH'(mag);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] tanh_grad_q312(
        input logic signed [DATA_WIDTH-1:0] grad,
        input logic signed [DATA_WIDTH-1:0] y);
        longint g;
        longint yl;
        longint yy;
        longint prod;
        longint top_val;
        g       = grad;
        yl      = y;
        yy      = (yl * yl) >>> FRAC_BITS;
        prod    = (g * (longint'(ONE_Q12) - yy)) >>> FRAC_BITS;
        top_val = (longint'(1) << (DATA_WIDTH - 1)) - 1;
        if (prod > top_val)
            prod = top_val;
        if (prod < -top_val - 1)
            prod = -top_val - 1;
        return DATA_WIDTH'(prod);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t due;
        if (!rst_n)
        begin
            due_results.delete();
            back_en   = 1'b1;
            due_count = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result_value: expected none, actual %0d", res_data.result_value);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res_data.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               want.result_value, res_data.result_value);
                        fail_count++;
                    end
                    if (res_data.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0d, actual %0d",
                               want.last_out, res_data.last_out);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (req_data.req_type == REQ_FWD)
                begin
                    due.result_value = tanh_q312(req_data.operand_value);
                    due.last_out     = req_data.last_in;
                    due_results.push_back(due);
                end
                else if (back_en)
                begin
                    due.result_value = tanh_grad_q312(req_data.operand_value,
                                                      req_data.saved_value);
                    due.last_out     = req_data.last_in;
                    due_results.push_back(due);
                end
            end
            if (cfg_valid && cfg_ready)
                back_en = cfg_data;
            due_count = due_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Stimulus, clock, reset and verdict for the tanh activation block.
module testbench;
    import tanh_af_pkg::*;

    localparam int RUN_LIMIT    = 300000;
    localparam int PHASE_ITEMS  = 340;
    localparam int IDLE_PERCENT = 28;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;
    int   errors;
    int   pending;
    logic calm = 1'b0;
    int   cycle_count = 0;

    tanh_activation_fwd_bwd u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tanh_activation_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tanh_activation_fwd_bwd verification failed");
            $finish;
        end
    end

    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ready = calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_element(input logic kind, input logic [15:0] op,
                                input logic [15:0] saved, input logic last);
        req_t r;
        r.req_type      = kind;
        r.operand_value = op;
        r.saved_value   = saved;
        r.last_in       = last;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = r;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic set_backward(input logic enable);
        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // let dropped backward requests drain from the pipeline
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = enable;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = 16'($urandom);
            3:       v = 16'(int'($urandom_range(0, 24576)) - 12288);
            4:       v = {$urandom_range(0, 511) >= 256 ? 9'h1ff : 9'($urandom),
                          $urandom_range(0, 1) ? 7'h7f : 7'h00};
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'h0000;
                    3:       v = 16'hffff;
                    default: v = 16'h8001;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_saved();
        if ($urandom_range(0, 1))
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    initial
    begin
        logic enable_plan [0:5];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        enable_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_element(REQ_FWD, 16'h0000, 16'h1234, 1'b0);
        send_element(REQ_BWD, 16'h7fff, 16'h8000, 1'b0);
        set_backward(1'b1);
        send_element(REQ_FWD, 16'h0001, 16'hffff, 1'b0);
        send_element(REQ_FWD, 16'h007f, 16'h0000, 1'b1);
        send_element(REQ_FWD, 16'h0080, 16'h7fff, 1'b0);
        send_element(REQ_FWD, 16'h1000, 16'h0000, 1'b0);
        send_element(REQ_FWD, 16'hf000, 16'h0000, 1'b1);
        send_element(REQ_FWD, 16'h7f80, 16'h0000, 1'b0);
        send_element(REQ_FWD, 16'h7f81, 16'h0000, 1'b0);
        send_element(REQ_FWD, 16'h7fff, 16'h8000, 1'b1);
        send_element(REQ_FWD, 16'h8000, 16'h7fff, 1'b0);
        send_element(REQ_FWD, 16'hffff, 16'h0000, 1'b1);
        send_element(REQ_BWD, 16'h7fff, 16'h0000, 1'b0);
        send_element(REQ_BWD, 16'h8000, 16'h0000, 1'b1);
        send_element(REQ_BWD, 16'h8000, 16'h7fff, 1'b0);
        send_element(REQ_BWD, 16'hffff, 16'h0001, 1'b1);
        send_element(REQ_BWD, 16'hffff, 16'h0fff, 1'b0);
        send_element(REQ_BWD, 16'h0001, 16'h1000, 1'b1);
        set_backward(1'b0);
        send_element(REQ_BWD, 16'h7fff, 16'h0000, 1'b1);
        send_element(REQ_FWD, 16'h0064, 16'h0000, 1'b0);
        send_element(REQ_BWD, 16'h8000, 16'h8000, 1'b0);
        send_element(REQ_FWD, 16'h8000, 16'h0000, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_backward(enable_plan[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                calm = (ph == 2) && (i < 250);
                send_element(logic'($urandom_range(0, 1)), pick_operand(), pick_saved(),
                             ($urandom_range(0, 7) == 0));
            end
            calm = 1'b0;
        end

        req_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("tanh_activation_fwd_bwd verification clean");
        else
            $display("tanh_activation_fwd_bwd verification failed");
        $finish;
    end

endmodule
